// ----- rtl/core/dependent_tempo_step_sequencer_defines.svh -----
// Assertion macros for the dependent tempo step sequencer.
// Taken in by the modules that carry concurrent checks; no other dependencies.
`ifndef DEPENDENT_TEMPO_STEP_SEQUENCER_DEFINES_SVH
`define DEPENDENT_TEMPO_STEP_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define DTSS_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high
`define DTSS_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/dtss_pkg.sv -----
// Shared constants, codes and controller/datapath command types for the
// dependent tempo step sequencer. No dependencies.
`timescale 1ns / 1ps

package dtss_pkg;

   localparam int DTSS_NUM_STEPS = 8;
   localparam int DTSS_FRAC_BITS = 8;

   localparam int PERIOD_W = 40;
   localparam int MPT_W    = 20;
   localparam int PROD_W   = 47;   // period times beats_old
   localparam int NUM_W    = 54;   // times 100
   localparam int DEN_W    = 17;   // beats_new times speed
   localparam int HOLD_W   = 10;
   localparam int DIV_CNT_W = 6;

   localparam logic [MPT_W-1:0]    MPT_RESET   = 20'd48000;
   localparam logic [PERIOD_W-1:0] PERIOD_MAX  = {PERIOD_W{1'b1}};
   localparam logic [HOLD_W-1:0]   COUNT_MAX   = {HOLD_W{1'b1}};
   localparam logic [DIV_CNT_W-1:0] DIV_LAST   = 6'd39;

   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_RESET = 2'd2;

   typedef struct packed {
      logic accept;
      logic tick;
      logic base_load;
      logic mul_old;
      logic mul_hundred;
      logic sat_check;
      logic div_step;
      logic update;
      logic scan_step;
      logic emit_read;
      logic emit_load;
   } dtss_cmd_type;

   typedef struct packed {
      logic saturate;
      logic div_done;
      logic advance;
      logic scan_hit;
   } dtss_status_type;

endpackage

// ----- rtl/core/dependent_tempo_step_sequencer.sv -----
// Top level of the dependent tempo step sequencer: controller and datapath.
// Depends on dtss_pkg, dtss_ctrl, dtss_datapath and dtss_ram.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_ready   mode, step entry fields
//   rsp_      out        rsp_valid/rsp_ready   gates, position, advanced flag
//   csr_      in         csr_valid/csr_ready   master period ticks
//
// A write, reset or unused request goes from acceptance through the emit states;
// a sample tick first passes the tick, base, multiply, saturation, divide (up to 40
// iterations, one quotient bit a cycle), update and scan (up to NUM_STEPS) states.
// Reset is synchronous; no clearing pass, step period entries carry valid bits.
// A stalled beat holds the next result back; configuration is always ready.
`timescale 1ns / 1ps

module dependent_tempo_step_sequencer #(
   parameter int NUM_STEPS = dtss_pkg::DTSS_NUM_STEPS,
   parameter int FRAC_BITS = dtss_pkg::DTSS_FRAC_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [2:0]  req_step_index,
   input  logic        req_step_on,
   input  logic [1:0]  req_step_reference,
   input  logic [6:0]  req_beats_old,
   input  logic [6:0]  req_beats_new,
   input  logic [9:0]  req_hold_beats,
   input  logic [9:0]  req_speed_hundredths,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_master_gate,
   output logic        rsp_step_gate,
   output logic [2:0]  rsp_step_position,
   output logic        rsp_step_advanced,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [19:0] csr_data
);

   dtss_pkg::dtss_cmd_type    cmd;
   dtss_pkg::dtss_status_type status;

   assign csr_ready = 1'b1;

   dtss_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode (req_mode),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status   (status),
      .cmd      (cmd)
   );

   dtss_datapath #(
      .NUM_STEPS(NUM_STEPS),
      .FRAC_BITS(FRAC_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_valid           (csr_valid & csr_ready),
      .csr_data            (csr_data),
      .req_mode            (req_mode),
      .req_step_index      (req_step_index),
      .req_step_on         (req_step_on),
      .req_step_reference  (req_step_reference),
      .req_beats_old       (req_beats_old),
      .req_beats_new       (req_beats_new),
      .req_hold_beats      (req_hold_beats),
      .req_speed_hundredths(req_speed_hundredths),
      .rsp_master_gate     (rsp_master_gate),
      .rsp_step_gate       (rsp_step_gate),
      .rsp_step_position   (rsp_step_position),
      .rsp_step_advanced   (rsp_step_advanced)
   );

endmodule

// ----- rtl/core/dtss_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dtss_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/dtss_ctrl.sv -----
// Sequencing state machine for the tempo step sequencer: handshakes and
// datapath commands. Depends on dtss_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "dependent_tempo_step_sequencer_defines.svh"

module dtss_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_mode,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  dtss_pkg::dtss_status_type status,
   output dtss_pkg::dtss_cmd_type   cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_TICK, ST_BASE, ST_MUL1, ST_MUL2, ST_SAT,
      ST_DIV, ST_UPD, ST_SCAN, ST_EMIT_RD, ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Decode commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = (req_mode == dtss_pkg::MODE_TICK) ? ST_TICK : ST_EMIT_RD;
            end
         end
         ST_TICK: begin
            cmd.tick = 1'b1;
            state_in = ST_BASE;
         end
         ST_BASE: begin
            cmd.base_load = 1'b1;
            state_in      = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul_old = 1'b1;
            state_in    = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul_hundred = 1'b1;
            state_in        = ST_SAT;
         end
         ST_SAT: begin
            cmd.sat_check = 1'b1;
            state_in      = status.saturate ? ST_UPD : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            cmd.update = 1'b1;
            state_in   = status.advance ? ST_SCAN : ST_EMIT_RD;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_hit) begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            cmd.emit_read = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit_load = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold result beat until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `DTSS_ASSERT_NXT(a_accept_leaves_idle, clock, reset, req_valid && req_ready, state_ff != ST_IDLE, "accepted beat did not start work")
   `DTSS_ASSERT_IMP(a_load_into_free_slot, clock, reset, cmd.emit_load, !rsp_valid_ff || rsp_ready, "result overwrote a pending beat")
   `DTSS_ASSERT_NXT(a_taken_beat_drains, clock, reset, rsp_valid_ff && rsp_ready && !cmd.emit_load, !rsp_valid_ff, "taken result beat repeated")

endmodule

// ----- rtl/core/dtss_datapath.sv -----
// Datapath of the tempo step sequencer: step table, phases, period
// multiply and iterative divide, step scan, result registers.
// Depends on dtss_pkg and dtss_ram.
`timescale 1ns / 1ps

module dtss_datapath #(
   parameter int NUM_STEPS = dtss_pkg::DTSS_NUM_STEPS,
   parameter int FRAC_BITS = dtss_pkg::DTSS_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dtss_pkg::dtss_cmd_type    cmd,
   output dtss_pkg::dtss_status_type status,
   input  logic                      csr_valid,
   input  logic [dtss_pkg::MPT_W-1:0] csr_data,
   input  logic [1:0]                req_mode,
   input  logic [2:0]                req_step_index,
   input  logic                      req_step_on,
   input  logic [1:0]                req_step_reference,
   input  logic [6:0]                req_beats_old,
   input  logic [6:0]                req_beats_new,
   input  logic [9:0]                req_hold_beats,
   input  logic [9:0]                req_speed_hundredths,
   output logic                      rsp_master_gate,
   output logic                      rsp_step_gate,
   output logic [2:0]                rsp_step_position,
   output logic                      rsp_step_advanced
);

   localparam int IW = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;
   localparam int PW = (IW > 3) ? IW : 3;
   localparam int PER_W = dtss_pkg::PERIOD_W;
   localparam logic [PER_W-1:0] PHASE_ONE = PER_W'(1) << FRAC_BITS;

   // Configuration register
   logic [dtss_pkg::MPT_W-1:0] mpt_ff;
   logic [dtss_pkg::MPT_W-1:0] mlen;

   always_ff @(posedge clock) begin
      if (reset) begin
         mpt_ff <= dtss_pkg::MPT_RESET;
      end else if (csr_valid) begin
         mpt_ff <= csr_data;
      end
   end

   assign mlen = (mpt_ff == '0) ? dtss_pkg::MPT_W'(1) : mpt_ff;

   // Step table
   logic [NUM_STEPS-1:0] on_ff;
   logic [1:0]           ref_ff   [NUM_STEPS];
   logic [6:0]           old_ff   [NUM_STEPS];
   logic [6:0]           new_ff   [NUM_STEPS];
   logic [9:0]           hold_ff  [NUM_STEPS];
   logic [9:0]           speed_ff [NUM_STEPS];
   logic [NUM_STEPS-1:0] pvalid_ff;

   // Sequence state
   logic [IW-1:0]          pos_ff;
   logic [IW-1:0]          scan_ff;
   logic [9:0]             count_ff;
   logic [dtss_pkg::MPT_W-1:0] mph_ff;
   logic [PER_W-1:0]       sph_ff;
   logic                   adv_ff;

   // Period arithmetic
   logic [1:0]                 cur_ref_ff;
   logic [IW-1:0]              ref_idx_ff;
   logic [6:0]                 cur_old_ff;
   logic [9:0]                 cur_hold_ff;
   logic [dtss_pkg::DEN_W-1:0] den_ff;
   logic [PER_W-1:0]           base_ff;
   logic [dtss_pkg::PROD_W-1:0] prod_ff;
   logic [dtss_pkg::NUM_W-1:0] num_ff;
   logic [dtss_pkg::DEN_W-1:0] rem_ff;
   logic [PER_W-1:0]           quo_ff;
   logic [dtss_pkg::DIV_CNT_W-1:0] div_cnt_ff;

   // Write decode
   logic [IW-1:0] wr_idx;
   logic          wr_ok;
   logic [1:0]    wr_ref;
   logic [1:0]    wr_ref_c;

   assign wr_idx   = IW'(req_step_index);
   assign wr_ok    = (5'(req_step_index) < 5'(NUM_STEPS));
   assign wr_ref   = (req_step_reference > 2'd2) ? 2'd2 : req_step_reference;
   assign wr_ref_c = (3'(wr_ref) > req_step_index) ? req_step_index[1:0] : wr_ref;

   // Tick decode: clamp reference to the playing step
   logic [1:0]          use_ref;
   logic [dtss_pkg::MPT_W-1:0] mph_inc;
   logic [6:0]          nb;
   logic [9:0]          spd;

   always_comb begin
      use_ref = (ref_ff[pos_ff] > 2'd2) ? 2'd2 : ref_ff[pos_ff];
      if (5'(use_ref) > 5'(pos_ff)) begin
         use_ref = 2'(pos_ff);
      end
   end

   assign mph_inc = mph_ff + dtss_pkg::MPT_W'(1);
   assign nb      = (new_ff[pos_ff] == '0) ? 7'd1 : new_ff[pos_ff];
   assign spd     = (speed_ff[pos_ff] == '0) ? 10'd1 : speed_ff[pos_ff];

   // Step period store
   logic             ram_rd_en;
   logic [IW-1:0]    ram_rd_addr;
   logic [PER_W-1:0] ram_rd_data;
   logic [IW-1:0]    tick_ref_idx;

   assign tick_ref_idx = pos_ff - IW'(use_ref);
   assign ram_rd_en    = cmd.tick | cmd.emit_read;
   assign ram_rd_addr  = cmd.tick ? tick_ref_idx : pos_ff;

   dtss_ram #(
      .WIDTH(PER_W),
      .DEPTH(NUM_STEPS)
   ) u_period_ram (
      .clock  (clock),
      .wr_en  (cmd.update),
      .wr_addr(pos_ff),
      .wr_data(quo_ff),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // Divide step and saturation test
   logic [dtss_pkg::DEN_W:0] div_trial;
   logic                     div_ge;

   assign div_trial = {rem_ff, quo_ff[PER_W-1]};
   assign div_ge    = (div_trial >= {1'b0, den_ff});

   // Period update: count periods, decide on advance
   logic [9:0] count_upd;
   logic       wrap_hit;

   assign wrap_hit = (sph_ff >= quo_ff);

   always_comb begin
      count_upd = count_ff;
      if (wrap_hit) begin
         if (cur_hold_ff != '0) begin
            count_upd = (count_ff == dtss_pkg::COUNT_MAX) ? count_ff : count_ff + 10'd1;
         end else begin
            count_upd = '0;
         end
      end
   end

   // Scan for the next active step
   logic [IW-1:0] scan_next;

   assign scan_next = (32'(scan_ff) == NUM_STEPS - 1) ? '0 : scan_ff + IW'(1);

   assign status.saturate = (57'(num_ff) >= {den_ff, PER_W'(0)});
   assign status.div_done = (div_cnt_ff == dtss_pkg::DIV_LAST);
   assign status.advance  = (count_upd != '0) && (count_upd >= cur_hold_ff);
   assign status.scan_hit = on_ff[scan_next];

   // Table and sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STEPS; i++) begin
            on_ff[i]    <= (i == 0);
            ref_ff[i]   <= 2'd0;
            old_ff[i]   <= 7'd1;
            new_ff[i]   <= 7'd1;
            hold_ff[i]  <= 10'd4;
            speed_ff[i] <= 10'd100;
         end
         pvalid_ff <= '0;
         pos_ff    <= '0;
         count_ff  <= '0;
         mph_ff    <= '0;
         sph_ff    <= '0;
         adv_ff    <= 1'b0;
      end else begin
         if (cmd.accept) begin
            adv_ff <= 1'b0;
            if (req_mode == dtss_pkg::MODE_WRITE && wr_ok) begin
               on_ff[wr_idx]    <= (wr_idx == '0) ? 1'b1 : req_step_on;
               ref_ff[wr_idx]   <= wr_ref_c;
               old_ff[wr_idx]   <= req_beats_old;
               new_ff[wr_idx]   <= req_beats_new;
               hold_ff[wr_idx]  <= req_hold_beats;
               speed_ff[wr_idx] <= req_speed_hundredths;
            end
            if (req_mode == dtss_pkg::MODE_RESET) begin
               pos_ff   <= '0;
               count_ff <= '0;
               mph_ff   <= '0;
               sph_ff   <= '0;
            end
         end
         // Advance both phases
         if (cmd.tick) begin
            sph_ff <= sph_ff + PHASE_ONE;
            mph_ff <= (mph_inc >= mlen) ? mph_inc - mlen : mph_inc;
         end
         // Store period, wrap the step phase, count periods
         if (cmd.update) begin
            pvalid_ff[pos_ff] <= 1'b1;
            if (wrap_hit) begin
               sph_ff <= sph_ff - quo_ff;
            end
            count_ff <= status.advance ? '0 : count_upd;
         end
         if (cmd.scan_step && status.scan_hit) begin
            pos_ff <= scan_next;
            adv_ff <= 1'b1;
         end
      end
   end

   // Period arithmetic registers
   always_ff @(posedge clock) begin
      if (cmd.tick) begin
         cur_ref_ff  <= use_ref;
         ref_idx_ff  <= tick_ref_idx;
         cur_old_ff  <= old_ff[pos_ff];
         cur_hold_ff <= hold_ff[pos_ff];
         den_ff      <= dtss_pkg::DEN_W'(nb) * dtss_pkg::DEN_W'(spd);
      end
      if (cmd.base_load) begin
         if (cur_ref_ff == 2'd0) begin
            base_ff <= PER_W'(mlen) << FRAC_BITS;
         end else begin
            base_ff <= pvalid_ff[ref_idx_ff] ? ram_rd_data : '0;
         end
      end
      if (cmd.mul_old) begin
         prod_ff <= dtss_pkg::PROD_W'(base_ff) * dtss_pkg::PROD_W'(cur_old_ff);
      end
      if (cmd.mul_hundred) begin
         num_ff <= dtss_pkg::NUM_W'(prod_ff) * dtss_pkg::NUM_W'(7'd100);
      end
      if (cmd.sat_check) begin
         if (status.saturate) begin
            quo_ff <= dtss_pkg::PERIOD_MAX;
         end else begin
            quo_ff <= num_ff[PER_W-1:0];
            rem_ff <= dtss_pkg::DEN_W'(num_ff[dtss_pkg::NUM_W-1:PER_W]);
         end
         div_cnt_ff <= '0;
      end
      // One quotient bit a cycle
      if (cmd.div_step) begin
         quo_ff     <= {quo_ff[PER_W-2:0], div_ge};
         rem_ff     <= div_ge ? dtss_pkg::DEN_W'(div_trial - {1'b0, den_ff})
                              : dtss_pkg::DEN_W'(div_trial);
         div_cnt_ff <= div_cnt_ff + dtss_pkg::DIV_CNT_W'(1);
      end
      if (cmd.scan_step) begin
         scan_ff <= scan_next;
      end else if (cmd.update) begin
         scan_ff <= pos_ff;
      end
   end

   // Result beat
   logic [PW-1:0] pos_wide;

   assign pos_wide = PW'(pos_ff);

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_master_gate   <= ({mph_ff, 1'b0} < {1'b0, mlen});
         rsp_step_gate     <= pvalid_ff[pos_ff] && ({sph_ff, 1'b0} < {1'b0, ram_rd_data});
         rsp_step_position <= pos_wide[2:0];
         rsp_step_advanced <= adv_ff;
      end
   end

endmodule
